/* rtl/wbit_pkg.sv */
// Shared types, constants and codes for the work/break interval timer.
package wbit_pkg;

   localparam int TIME_WIDTH    = 24;
   localparam int COUNT_WIDTH   = 16;
   localparam int IVL_WIDTH     = 4;
   localparam int FUNC_WIDTH    = 3;
   localparam int PHASE_WIDTH   = 3;
   localparam int CSR_IDX_WIDTH = 8;
   localparam int CSR_DAT_WIDTH = 24;
   localparam int MOD_CNT_WIDTH = $clog2(COUNT_WIDTH + 1);
   localparam int MOD_IDX_WIDTH = $clog2(COUNT_WIDTH);

   localparam logic [TIME_WIDTH-1:0] WORK_RESET  = TIME_WIDTH'(1500);
   localparam logic [TIME_WIDTH-1:0] SHORT_RESET = TIME_WIDTH'(300);
   localparam logic [TIME_WIDTH-1:0] LONG_RESET  = TIME_WIDTH'(900);
   localparam logic [IVL_WIDTH-1:0]  IVL_RESET   = IVL_WIDTH'(4);

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_WORK_SECONDS  = CSR_IDX_WIDTH'(0);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SHORT_SECONDS = CSR_IDX_WIDTH'(1);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LONG_SECONDS  = CSR_IDX_WIDTH'(2);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LONG_INTERVAL = CSR_IDX_WIDTH'(3);

   localparam logic [PHASE_WIDTH-1:0] PH_IDLE   = 3'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_WORK   = 3'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_SHORT  = 3'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_LONG   = 3'd3;
   localparam logic [PHASE_WIDTH-1:0] PH_PAUSED = 3'd4;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FN_TICK   = 3'd0,
      FN_WORK   = 3'd1,
      FN_BREAK  = 3'd2,
      FN_PAUSE  = 3'd3,
      FN_RESUME = 3'd4,
      FN_CLEAR  = 3'd5,
      FN_LOAD   = 3'd6,
      FN_READ   = 3'd7
   } func_type;

   typedef struct packed {
      func_type              func;
      logic [TIME_WIDTH-1:0] load_value;
   } req_type;

   typedef struct packed {
      logic [PHASE_WIDTH-1:0] phase;
      logic [PHASE_WIDTH-1:0] pause_origin;
      logic [TIME_WIDTH-1:0]  seconds_left;
      logic [COUNT_WIDTH-1:0] done_count;
      logic                   is_running;
      logic                   finished_flag;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic mod_start;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic is_break;
      logic mod_busy;
   } status_type;

endpackage

/* rtl/work_break_interval_timer.sv */
// Work/break interval timer: top level joining controller and datapath.
//
// Usage:
//   req_ channel: one command transaction per item (tick, start work, start
//   break, pause, resume, clear, load seconds, read finished flag). A
//   transaction is taken when req_valid is high and req_stall is low.
//   rsp_ channel: one result transaction per command, carrying the timer
//   state after the command. Taken when rsp_valid is high and rsp_stall low.
//   csr_ channel: setting writes (work, short break, long break lengths and
//   the long break interval); csr_ready is always high. Write only while
//   the block is idle.
// Sequencing: a command other than start break is captured on acceptance and
//   written into the result register from the execute state once the output
//   register is free; the next command is taken only after that. Start break
//   first runs the bit-serial remainder unit, which walks the 16-bit work
//   count one bit per cycle, before the same execute step.
// Reset: settings return to their defaults, the timer goes idle with zero
//   seconds and count, no result pending.
// Stall: a pending result holds in the output register; one more command
//   can be accepted and waits for the register to drain.
module work_break_interval_timer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  wbit_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output wbit_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wbit_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [wbit_pkg::CSR_DAT_WIDTH-1:0] csr_data
);
   import wbit_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   wbit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   wbit_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

/* rtl/wbit_mod.sv */
// Bit-serial remainder of the completed-work count by the long break interval.
module wbit_mod (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [wbit_pkg::COUNT_WIDTH-1:0] dividend,
   input  logic [wbit_pkg::IVL_WIDTH-1:0]   divisor,
   output logic                            busy,
   output logic [wbit_pkg::IVL_WIDTH-1:0]   remainder
);
   import wbit_pkg::*;

   logic                     busy_ff, busy_in;
   logic [MOD_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [IVL_WIDTH-1:0]     rem_ff, rem_in;
   logic [MOD_CNT_WIDTH-1:0] cnt_dec;
   logic [IVL_WIDTH:0]       shifted;

   // restoring step, one dividend bit per cycle, msb first
   always_comb begin
      cnt_dec = cnt_ff - MOD_CNT_WIDTH'(1);
      shifted = {rem_ff, dividend[cnt_dec[MOD_IDX_WIDTH-1:0]]};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = MOD_CNT_WIDTH'(COUNT_WIDTH);
         rem_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_dec;
         if (shifted >= {1'b0, divisor}) begin
            rem_in = IVL_WIDTH'(shifted - {1'b0, divisor});
         end else begin
            rem_in = IVL_WIDTH'(shifted);
         end
         if (cnt_dec == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/wbit_ctrl.sv */
// Controller: accepts a command, sequences the remainder unit and result hand-off.
module wbit_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output wbit_pkg::cmd_type     cmd,
   input  wbit_pkg::status_type  status
);
   import wbit_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MOD  = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      cmd.capture   = accept;
      cmd.mod_start = 1'b0;
      cmd.exec      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (status.is_break) begin
                  cmd.mod_start = 1'b1;
                  state_in      = ST_MOD;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_MOD: begin
            if (!status.mod_busy) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.exec || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/wbit_dp.sv */
// Datapath: setting registers, timer state, command execution and result register.
module wbit_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  wbit_pkg::req_type                 req_data,
   output wbit_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write,
   input  logic [wbit_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [wbit_pkg::CSR_DAT_WIDTH-1:0] csr_data,
   input  wbit_pkg::cmd_type                 cmd,
   output wbit_pkg::status_type              status
);
   import wbit_pkg::*;

   logic [TIME_WIDTH-1:0]  work_sec_ff, short_sec_ff, long_sec_ff;
   logic [IVL_WIDTH-1:0]   interval_ff;

   req_type                req_ff;
   rsp_type                rsp_ff, rsp_in;

   logic [PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic [PHASE_WIDTH-1:0] saved_ff, saved_in;
   logic [TIME_WIDTH-1:0]  remaining_ff, remaining_in;
   logic [COUNT_WIDTH-1:0] done_ff, done_in;
   logic                   active_ff, active_in;
   logic                   flag_ff, flag_in;
   logic                   flag_out;

   logic                   mod_busy;
   logic [IVL_WIDTH-1:0]   mod_rem;
   logic [TIME_WIDTH-1:0]  csr_time;
   logic [IVL_WIDTH-1:0]   csr_ivl;

   wbit_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (done_ff),
      .divisor   (interval_ff),
      .busy      (mod_busy),
      .remainder (mod_rem)
   );

   assign status.is_break = (req_data.func == FN_BREAK);
   assign status.mod_busy = mod_busy;

   assign csr_time = TIME_WIDTH'(csr_data);
   assign csr_ivl  = csr_data[IVL_WIDTH-1:0];

   // zero writes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         work_sec_ff  <= WORK_RESET;
         short_sec_ff <= SHORT_RESET;
         long_sec_ff  <= LONG_RESET;
         interval_ff  <= IVL_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_WORK_SECONDS && csr_time != '0) begin
            work_sec_ff <= csr_time;
         end
         if (csr_index == CSR_SHORT_SECONDS && csr_time != '0) begin
            short_sec_ff <= csr_time;
         end
         if (csr_index == CSR_LONG_SECONDS && csr_time != '0) begin
            long_sec_ff <= csr_time;
         end
         if (csr_index == CSR_LONG_INTERVAL && csr_ivl != '0) begin
            interval_ff <= csr_ivl;
         end
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      saved_in     = saved_ff;
      remaining_in = remaining_ff;
      done_in      = done_ff;
      active_in    = active_ff;
      flag_in      = flag_ff;
      case (req_ff.func)
         FN_TICK: begin
            if (active_ff && phase_ff != PH_IDLE) begin
               if (remaining_ff != '0) begin
                  remaining_in = remaining_ff - TIME_WIDTH'(1);
               end else begin
                  flag_in   = 1'b1;
                  active_in = 1'b0;
                  if (phase_ff == PH_WORK) begin
                     if (done_ff != '1) begin
                        done_in = done_ff + COUNT_WIDTH'(1);
                     end
                     phase_in = PH_IDLE;
                     saved_in = PH_IDLE;
                  end else if (phase_ff == PH_SHORT || phase_ff == PH_LONG) begin
                     phase_in = PH_IDLE;
                     saved_in = PH_IDLE;
                  end
               end
            end
         end
         FN_WORK: begin
            phase_in     = PH_WORK;
            remaining_in = work_sec_ff;
            active_in    = 1'b1;
            flag_in      = 1'b0;
         end
         FN_BREAK: begin
            if (done_ff != '0 && mod_rem == '0) begin
               phase_in     = PH_LONG;
               remaining_in = long_sec_ff;
            end else begin
               phase_in     = PH_SHORT;
               remaining_in = short_sec_ff;
            end
            active_in = 1'b1;
            flag_in   = 1'b0;
         end
         FN_PAUSE: begin
            if (active_ff && phase_ff != PH_IDLE) begin
               active_in = 1'b0;
               saved_in  = phase_ff;
               phase_in  = PH_PAUSED;
            end
         end
         FN_RESUME: begin
            if (phase_ff == PH_PAUSED) begin
               active_in = 1'b1;
               phase_in  = (saved_ff != PH_IDLE) ? saved_ff : PH_WORK;
               saved_in  = PH_IDLE;
            end
         end
         FN_CLEAR: begin
            phase_in     = PH_IDLE;
            saved_in     = PH_IDLE;
            remaining_in = '0;
            done_in      = '0;
            active_in    = 1'b0;
            flag_in      = 1'b0;
         end
         FN_LOAD: begin
            remaining_in = req_ff.load_value;
            flag_in      = 1'b0;
         end
         default: begin
         end
      endcase
      // read reports the flag, then clears it
      flag_out = flag_in;
      if (req_ff.func == FN_READ) begin
         flag_in = 1'b0;
      end
      rsp_in.phase         = phase_in;
      rsp_in.pause_origin  = saved_in;
      rsp_in.seconds_left  = remaining_in;
      rsp_in.done_count    = done_in;
      rsp_in.is_running    = active_in;
      rsp_in.finished_flag = flag_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         saved_ff     <= PH_IDLE;
         remaining_ff <= '0;
         done_ff      <= '0;
         active_ff    <= 1'b0;
         flag_ff      <= 1'b0;
      end else if (cmd.exec) begin
         phase_ff     <= phase_in;
         saved_ff     <= saved_in;
         remaining_ff <= remaining_in;
         done_ff      <= done_in;
         active_ff    <= active_in;
         flag_ff      <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
